// ----- rtl/pdga_pkg.sv -----
// Package for the Poisson-disk grid acceptance engine.
// Holds request and status codes and the queue entry type; no dependencies.
package pdga_pkg;

  localparam int CoordW = 21;
  localparam int UCoordW = 20;
  localparam int FracBits = 8;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_SEED  = 2'd1,
    REQ_TEST  = 2'd2,
    REQ_TEST3 = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_STORED  = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_CLOSE   = 2'd2,
    ST_CLEARED = 2'd3
  } status_t;

  localparam logic [2:0] REG_AREA_W    = 3'd0;
  localparam logic [2:0] REG_AREA_H    = 3'd1;
  localparam logic [2:0] REG_SPACING   = 3'd2;
  localparam logic [2:0] REG_CELL_SIZE = 3'd3;
  localparam logic [2:0] REG_GRID_COLS = 3'd4;
  localparam logic [2:0] REG_GRID_ROWS = 3'd5;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic [1:0]           kind;   // status_t code for immediate results, else ST_STORED
    logic                 imm;    // result is final, no grid work
    logic                 seed;
    logic [UCoordW-1:0]   ux;
    logic [UCoordW-1:0]   uy;
  } job_t;

endpackage

// ----- rtl/pdga_front.sv -----
// Front part: accepts items, range-checks them and classifies them.
// Depends on pdga_pkg.
module pdga_front (
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             req_type,
  input  logic signed [pdga_pkg::CoordW-1:0] cand_x,
  input  logic signed [pdga_pkg::CoordW-1:0] cand_y,
  input  logic [11:0]            area_width,
  input  logic [11:0]            area_height,
  output logic                   q_valid,
  input  logic                   q_full,
  output pdga_pkg::job_t         q_job
);
  import pdga_pkg::*;

  logic [UCoordW:0] lim_x, lim_y;
  logic outside;

  assign lim_x = {{(UCoordW+1-12){1'b0}}, area_width} << FracBits;
  assign lim_y = {{(UCoordW+1-12){1'b0}}, area_height} << FracBits;
  assign outside = cand_x[CoordW-1] || cand_y[CoordW-1] ||
                   ({1'b0, cand_x[UCoordW-1:0]} >= lim_x) ||
                   ({1'b0, cand_y[UCoordW-1:0]} >= lim_y);

  assign in_stall = q_full;
  assign q_valid  = in_valid && !q_full;

  always_comb begin
    q_job.ux   = cand_x[UCoordW-1:0];
    q_job.uy   = cand_y[UCoordW-1:0];
    q_job.seed = (req_type == REQ_SEED);
    q_job.imm  = 1'b1;
    q_job.kind = ST_STORED;
    if (req_type == REQ_CLEAR) begin
      q_job.kind = ST_CLEARED;
    end else if (outside) begin
      q_job.kind = ST_OUTSIDE;
    end else begin
      q_job.imm = 1'b0;
    end
  end
endmodule

// ----- rtl/pdga_queue.sv -----
// Two-entry queue between front and back parts.
// Depends on pdga_pkg.
module pdga_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  pdga_pkg::job_t wdata,
  output logic           full,
  output logic           nempty,
  input  logic           rd,
  output pdga_pkg::job_t rdata
);
  import pdga_pkg::*;

  job_t       ent [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign full   = (cnt == 2'd2);
  assign nempty = (cnt != 2'd0);
  assign rdata  = ent[rp];

  always_ff @(posedge clk) begin
    if (wr) ent[wp] <= wdata;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

// ----- rtl/pdga_back.sv -----
// Back part: cell index division, 5x5 neighborhood scan over the grid memory,
// insert, clear sweep and result register. Depends on pdga_pkg.
module pdga_back #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  input  pdga_pkg::job_t job,
  output logic           job_take,
  input  logic [15:0]    spacing,
  input  logic [15:0]    cell_size,
  input  logic [6:0]     grid_cols,
  input  logic [6:0]     grid_rows,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     status,
  output logic [5:0]     cell_col,
  output logic [5:0]     cell_row
);
  import pdga_pkg::*;

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int AW = CW + RW;
  localparam int DEPTH = 1 << AW;
  localparam int GW = (CW > RW ? CW : RW) + 1;

  typedef enum logic [7:0] {
    S_CLR   = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,
    S_WRAP  = 8'b0000_1000,
    S_RD    = 8'b0001_0000,
    S_CMP   = 8'b0010_0000,
    S_SQ    = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state;

  // memory: {x, y}, plus epoch tag
  logic [2*UCoordW-1:0] mem_d [DEPTH];
  logic [1:0]           mem_e [DEPTH];
  logic [2*UCoordW-1:0] rd_d;
  logic [1:0]           rd_e;
  logic [1:0]           epoch;
  logic                 wr_en;
  logic [AW-1:0]        wr_a, rd_a;
  logic [2*UCoordW-1:0] wr_d;
  logic [1:0]           wr_e;
  logic [AW-1:0]        clr_a;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_d[wr_a] <= wr_d;
      mem_e[wr_a] <= wr_e;
    end
    rd_d <= mem_d[rd_a];
    rd_e <= mem_e[rd_a];
  end

  // clamp dimensions
  logic [GW-1:0] ncols, nrows;
  always_comb begin
    if (grid_cols == 7'd0) ncols = GW'(1);
    else if ({25'd0, grid_cols} > 32'(MAX_COLS)) ncols = GW'(MAX_COLS);
    else ncols = GW'(grid_cols);
    if (grid_rows == 7'd0) nrows = GW'(1);
    else if ({25'd0, grid_rows} > 32'(MAX_ROWS)) nrows = GW'(MAX_ROWS);
    else nrows = GW'(grid_rows);
  end

  logic [15:0] csz;
  assign csz = (cell_size == 16'd0) ? 16'd1 : cell_size;

  // restoring divider, both quotients in parallel, one bit a cycle
  logic [UCoordW-1:0] qx, qy;
  logic [15:0]        rx, ry;
  logic [4:0]         bitc;
  logic [16:0]        rx_s, ry_s;
  assign rx_s = {rx, qx[UCoordW-1]};
  assign ry_s = {ry, qy[UCoordW-1]};

  logic [UCoordW-1:0] ux, uy;
  logic               seed;
  logic [GW-1:0]      col, row;   // wrapped own cell
  logic [2:0]         dc, dr;
  logic               hit;

  // neighbor cell: own cell plus an offset of -2..+2, wrapped into [0, n)
  function automatic logic [GW-1:0] wrap_off(input logic [GW-1:0] b,
                                             input logic [2:0] d,
                                             input logic [GW-1:0] n);
    logic signed [GW+1:0] v;
    begin
      v = $signed({2'b00, b}) + $signed({{(GW-1){1'b0}}, d}) - (GW+2)'(2);
      if (v < 0) v = v + $signed({2'b00, n});
      if (v < 0) v = v + $signed({2'b00, n});
      if (v >= $signed({2'b00, n})) v = v - $signed({2'b00, n});
      if (v >= $signed({2'b00, n})) v = v - $signed({2'b00, n});
      wrap_off = v[GW-1:0];
    end
  endfunction

  // own cell: quotient modulo grid size, one shifted compare-subtract a cycle
  logic [4:0]            redk;
  logic [UCoordW+GW-1:0] mx, my;
  logic [UCoordW-1:0]    qxr, qyr;
  assign mx  = {{UCoordW{1'b0}}, ncols} << redk;
  assign my  = {{UCoordW{1'b0}}, nrows} << redk;
  assign qxr = ({{GW{1'b0}}, qx} >= mx) ? qx - mx[UCoordW-1:0] : qx;
  assign qyr = ({{GW{1'b0}}, qy} >= my) ? qy - my[UCoordW-1:0] : qy;

  logic [GW-1:0] nc, nr;
  assign nc = wrap_off(col, dc, ncols);
  assign nr = wrap_off(row, dr, nrows);

  // distance
  logic [UCoordW-1:0] sx, sy, ddx, ddy;
  logic [2*UCoordW:0] d2;
  logic [31:0]        md2;
  logic [2*UCoordW-1:0] px, py;
  assign sx = rd_d[2*UCoordW-1:UCoordW];
  assign sy = rd_d[UCoordW-1:0];
  always_ff @(posedge clk) begin
    ddx <= (sx > ux) ? sx - ux : ux - sx;
    ddy <= (sy > uy) ? sy - uy : uy - sy;
    px  <= ddx * ddx;
    py  <= ddy * ddy;
  end
  assign d2  = {1'b0, px} + {1'b0, py};
  assign md2 = {16'd0, spacing} * {16'd0, spacing};

  logic [1:0] cmp_ph;
  logic       rd_ok;

  always_comb begin
    wr_en = 1'b0;
    wr_a  = clr_a;
    wr_d  = '0;
    wr_e  = epoch - 2'd1;
    if (state == S_CLR) begin
      wr_en = 1'b1;
    end else if (state == S_DONE && !out_valid && !hit) begin
      wr_en = 1'b1;
      wr_a  = AW'({row[RW-1:0], col[CW-1:0]});
      wr_d  = {ux, uy};
      wr_e  = epoch;
    end
  end

  always_comb begin
    rd_a = AW'({nr[RW-1:0], nc[CW-1:0]});
  end

  assign job_take = (state == S_IDLE) && job_valid &&
                    !(job.imm && out_valid && out_stall);

  logic res_load;
  assign res_load = (job_take && job.imm) || (state == S_DONE && !out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_a    <= '0;
      epoch    <= 2'd1;
      out_valid <= 1'b0;
      status <= '0; cell_col <= '0; cell_row <= '0;
    end else begin
      if (res_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        S_CLR: begin
          clr_a <= clr_a + AW'(1);
          if (clr_a == AW'(DEPTH-1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (job_take) begin
            ux <= job.ux; uy <= job.uy; seed <= job.seed;
            if (job.imm) begin
              status <= job.kind;
              cell_col <= '0; cell_row <= '0;
              if (job.kind == ST_CLEARED) begin
                // new epoch; if it wraps into stale tags, sweep the memory
                if (epoch == 2'd3) begin
                  epoch <= 2'd1;
                  clr_a <= '0;
                  state <= S_CLR;
                end else begin
                  epoch <= epoch + 2'd1;
                end
              end
            end else begin
              qx <= job.ux; qy <= job.uy; rx <= '0; ry <= '0;
              bitc <= '0;
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          qx <= {qx[UCoordW-2:0], rx_s >= {1'b0, csz}};
          qy <= {qy[UCoordW-2:0], ry_s >= {1'b0, csz}};
          rx <= (rx_s >= {1'b0, csz}) ? 16'(rx_s - {1'b0, csz}) : rx_s[15:0];
          ry <= (ry_s >= {1'b0, csz}) ? 16'(ry_s - {1'b0, csz}) : ry_s[15:0];
          bitc <= bitc + 5'd1;
          if (bitc == 5'(UCoordW-1)) begin
            state <= S_WRAP;
            redk <= 5'(UCoordW-1);
          end
        end
        S_WRAP: begin
          qx <= qxr;
          qy <= qyr;
          redk <= redk - 5'd1;
          if (redk == 5'd0) begin
            col <= qxr[GW-1:0];
            row <= qyr[GW-1:0];
            dc <= 3'd0; dr <= 3'd0;
            hit <= 1'b0;
            cmp_ph <= '0;
            state <= seed ? S_DONE : S_RD;
          end
        end
        S_RD: begin
          // rd_a presented now; data arrives next cycle
          state <= S_CMP;
          cmp_ph <= '0;
        end
        S_CMP: begin
          // wait out the difference and square registers
          cmp_ph <= cmp_ph + 2'd1;
          if (cmp_ph == 2'd0) rd_ok <= (rd_e == epoch);
          if (cmp_ph == 2'd2) begin
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (rd_ok && d2 < {9'd0, md2}) begin
            hit <= 1'b1;
            state <= S_DONE;
          end else if (dr == 3'd4) begin
            dr <= 3'd0;
            if (dc == 3'd4) state <= S_DONE;
            else begin
              dc <= dc + 3'd1;
              state <= S_RD;
            end
          end else begin
            dr <= dr + 3'd1;
            state <= S_RD;
          end
        end
        S_DONE: begin
          if (!out_valid) begin
            status <= hit ? ST_CLOSE : ST_STORED;
            cell_col <= 6'(col);
            cell_row <= 6'(row);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/poisson_disk_grid_accept.sv -----
// Top level of the Poisson-disk grid acceptance engine.
// Depends on pdga_pkg, pdga_front, pdga_queue and pdga_back.
//
// A clear or an out-of-area point is registered in the queue and then loaded
// straight into the result register. A seed runs a 20-step bit-serial divider for
// the cell index, a 20-step shift-and-subtract reduction of that index modulo the
// grid size and a hand-over to the result register. A candidate test adds 25 grid
// reads, each through memory read, difference, square and compare, fewer
// when a close point is found early. Clear is an epoch bump; every third clear
// and reset start a sweep of all 2^(clog2(MAX_COLS)+clog2(MAX_ROWS)) entries (4096
// by default) during which no item is taken. A stalled result keeps the back part
// from offering its next result; the two-entry queue then fills and the input stalls.
module poisson_disk_grid_accept #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic signed [20:0] cand_x,
  input  logic signed [20:0] cand_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [5:0]  cell_col,
  output logic [5:0]  cell_row
);
  import pdga_pkg::*;

  logic [11:0] area_width, area_height;
  logic [15:0] spacing, cell_size;
  logic [6:0]  grid_cols, grid_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      area_width <= 12'd256; area_height <= 12'd256;
      spacing <= 16'd2560; cell_size <= 16'd1810;
      grid_cols <= 7'd64; grid_rows <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AREA_W:    area_width  <= cfg_data[11:0];
        REG_AREA_H:    area_height <= cfg_data[11:0];
        REG_SPACING:   spacing     <= cfg_data;
        REG_CELL_SIZE: cell_size   <= cfg_data;
        REG_GRID_COLS: grid_cols   <= cfg_data[6:0];
        REG_GRID_ROWS: grid_rows   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic q_wr, q_full, q_ne, q_rd;
  job_t q_in, q_out;

  pdga_front u_front (
    .in_valid, .in_stall, .req_type, .cand_x, .cand_y,
    .area_width, .area_height,
    .q_valid(q_wr), .q_full, .q_job(q_in)
  );

  pdga_queue u_queue (
    .clk, .rst, .wr(q_wr), .wdata(q_in), .full(q_full),
    .nempty(q_ne), .rd(q_rd), .rdata(q_out)
  );

  pdga_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_back (
    .clk, .rst, .job_valid(q_ne), .job(q_out), .job_take(q_rd),
    .spacing, .cell_size, .grid_cols, .grid_rows,
    .out_valid, .out_stall, .status, .cell_col, .cell_row
  );
endmodule

// ----- rtl/pdga_checker.sv -----
// Port-level checks for the acceptance engine, bound to the top level.
// Depends on pdga_pkg.
module pdga_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] status,
  input logic [5:0] cell_col,
  input logic [5:0] cell_row
);
  import pdga_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status))
    else $error("result dropped while stalled");

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_OUTSIDE || status == ST_CLEARED) |->
      cell_col == 6'd0 && cell_row == 6'd0)
    else $error("cell fields not zero");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");
endmodule

bind poisson_disk_grid_accept pdga_checker u_chk (
  .clk, .rst, .out_valid, .out_stall, .status, .cell_col, .cell_row
);

// ----- tb/tb_poisson_disk_grid_accept.sv -----
// Self-checking testbench for poisson_disk_grid_accept.
// Depends on pdga_pkg and the RTL; holds a grid-store predictor, a
// valid/stall item driver, a stalling receiver and a result checker.
`timescale 1ns / 1ps

module tb_poisson_disk_grid_accept;
  import pdga_pkg::*;

  localparam int NCOLS = 64;
  localparam int NROWS = 64;
  localparam int NCELLS = NCOLS * NROWS;
  localparam int FRAC = 8;

  typedef struct {
    status_t    st;
    logic [5:0] col;
    logic [5:0] row;
  } grid_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_AREA_W;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] req_type = REQ_CLEAR;
  logic signed [20:0] cand_x = '0;
  logic signed [20:0] cand_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic [5:0] cell_col;
  logic [5:0] cell_row;

  poisson_disk_grid_accept u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .cand_x(cand_x), .cand_y(cand_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .cell_col(cell_col), .cell_row(cell_row)
  );

  always #1 clk = ~clk;

  // predictor copy of registers and grid store
  logic [11:0] m_area_w, m_area_h;
  logic [15:0] m_spacing, m_cell_size;
  logic [6:0]  m_cols, m_rows;
  bit          g_valid [NCELLS];
  longint      g_x [NCELLS];
  longint      g_y [NCELLS];

  grid_result_t expected_q[$];
  int  failures = 0;
  bit  no_gaps = 1'b0;
  bit  quiet_rx = 1'b0;
  bit  hold_req = 1'b0;
  longint last_x = 0, last_y = 0;

  function automatic longint wrap_cell(longint i, longint n);
    if (i < 0) i += n;
    if (i >= n) i -= n;
    if (i < 0 || i >= n) begin
      i = i % n;
      if (i < 0) i += n;
    end
    return i;
  endfunction

  function automatic longint clamp_dim(longint v, longint maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void clear_grid();
    for (int i = 0; i < NCELLS; i++) g_valid[i] = 1'b0;
  endfunction

  function automatic grid_result_t grid_accept(logic [1:0] req, logic signed [20:0] x,
                                               logic signed [20:0] y);
    grid_result_t r;
    longint sx, sy, cols, rows, cs, col, row, c, rr, a, ddx, ddy, d2;
    sx = x;
    sy = y;
    cols = clamp_dim(m_cols, NCOLS);
    rows = clamp_dim(m_rows, NROWS);
    cs = (m_cell_size == 0) ? 1 : m_cell_size;
    r.st = ST_STORED;
    r.col = '0;
    r.row = '0;
    if (req == REQ_CLEAR) begin
      clear_grid();
      r.st = ST_CLEARED;
      return r;
    end
    if (sx < 0 || sy < 0 || sx >= (longint'(m_area_w) << FRAC) ||
        sy >= (longint'(m_area_h) << FRAC)) begin
      r.st = ST_OUTSIDE;
      return r;
    end
    col = sx / cs;
    row = sy / cs;
    if (req != REQ_SEED) begin
      d2 = longint'(m_spacing) * longint'(m_spacing);
      for (int dc = -2; dc <= 2; dc++) begin
        for (int dr = -2; dr <= 2; dr++) begin
          c = wrap_cell(col + dc, cols);
          rr = wrap_cell(row + dr, rows);
          a = rr * NCOLS + c;
          if (g_valid[a]) begin
            ddx = (g_x[a] > sx) ? g_x[a] - sx : sx - g_x[a];
            ddy = (g_y[a] > sy) ? g_y[a] - sy : sy - g_y[a];
            if (ddx * ddx + ddy * ddy < d2) begin
              r.st = ST_CLOSE;
              r.col = 6'(wrap_cell(col, cols));
              r.row = 6'(wrap_cell(row, rows));
              return r;
            end
          end
        end
      end
    end
    col = wrap_cell(col, cols);
    row = wrap_cell(row, rows);
    a = row * NCOLS + col;
    g_valid[a] = 1'b1;
    g_x[a] = sx;
    g_y[a] = sy;
    last_x = sx;
    last_y = sy;
    r.col = 6'(col);
    r.row = 6'(row);
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // ---------------- driver side ----------------
  task automatic send_item(logic [1:0] req, logic signed [20:0] x, logic signed [20:0] y);
    int gap;
    grid_result_t r;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_type <= req;
    cand_x <= x;
    cand_y <= y;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = grid_accept(req, x, y);
    expected_q.insert(expected_q.size(), r);
    @(negedge clk);
  endtask

  // let everything in flight come out; a clear sweep can still be running afterwards
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_AREA_W:    m_area_w = val[11:0];
      REG_AREA_H:    m_area_h = val[11:0];
      REG_SPACING:   m_spacing = val;
      REG_CELL_SIZE: m_cell_size = val;
      REG_GRID_COLS: m_cols = val[6:0];
      REG_GRID_ROWS: m_rows = val[6:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int w, int h, int md, int cs, int cols, int rows);
    write_reg(REG_AREA_W, 16'(w));
    write_reg(REG_AREA_H, 16'(h));
    write_reg(REG_SPACING, 16'(md));
    write_reg(REG_CELL_SIZE, 16'(cs));
    write_reg(REG_GRID_COLS, 16'(cols));
    write_reg(REG_GRID_ROWS, 16'(rows));
  endtask

  task automatic send_random_item();
    int p;
    longint lim_x, lim_y, nx, ny, span;
    logic [1:0] req;
    p = $urandom_range(0, 99);
    lim_x = longint'(m_area_w) << FRAC;
    lim_y = longint'(m_area_h) << FRAC;
    if (p < 2) begin
      send_item(REQ_CLEAR, 21'($urandom), 21'($urandom));
      return;
    end
    if (p < 14) begin
      // noise over the whole coordinate range
      send_item(2'($urandom_range(1, 3)), 21'($urandom), 21'($urandom));
      return;
    end
    p = $urandom_range(0, 99);
    req = (p < 20) ? REQ_SEED : (p < 27) ? REQ_TEST3 : REQ_TEST;
    if ($urandom_range(0, 2) == 0) begin
      span = 2 * longint'(m_spacing) + 1;
      nx = last_x + longint'($urandom_range(0, 2 * span)) - span;
      ny = last_y + longint'($urandom_range(0, 2 * span)) - span;
    end else begin
      nx = $urandom_range(0, 32'(lim_x - 1));
      ny = $urandom_range(0, 32'(lim_y - 1));
    end
    send_item(req, 21'(nx), 21'(ny));
  endtask

  // ---------------- tests ----------------
  task automatic test_directed();
    send_item(REQ_CLEAR, 21'sd0, 21'sd0);
    send_item(REQ_TEST, 21'sd0, 21'sd0);          // (0,0) accepted on empty grid
    send_item(REQ_TEST, 21'sd1, 21'sd1);          // too close to a point at origin
    send_item(REQ_SEED, 21'sd5, 21'sd5);          // seed skips the spacing test
    send_item(REQ_TEST3, 21'sd300, 21'sd200);     // type three acts as a test
    send_item(REQ_SEED, -21'sd1, 21'sd10);        // seed outside area
    send_item(REQ_TEST, 21'sd10, -21'sd1);
    send_item(REQ_TEST, 21'sd65536, 21'sd100);    // x exactly at width
    send_item(REQ_TEST, 21'sd100, 21'sd65536);
    send_item(REQ_TEST, 21'sd65535, 21'sd65535);  // last pixel corner
    send_item(REQ_TEST, 21'sd1048575, 21'sd1048575);
    send_item(REQ_TEST, 21'sh100000, 21'sh100000); // most negative coordinate
    send_item(REQ_TEST, 21'sd65000, 21'sd2000);   // column 35, no wrap onto the origin column
    send_item(REQ_TEST, 21'sd30000, 21'sd30000);
    send_item(REQ_TEST, 21'sd30000 + 21'sd2559, 21'sd30000);
    send_item(REQ_TEST, 21'sd30000 + 21'sd2560, 21'sd30000);
    send_item(REQ_CLEAR, 21'sd0, 21'sd0);
    send_item(REQ_TEST, 21'sd1, 21'sd1);          // empty again after clear
    drain();
  endtask

  task automatic test_config_extremes();
    // smallest everything, zero cell size and zero grid size
    set_config(1, 1, 1, 0, 0, 0);
    send_item(REQ_TEST, 21'sd0, 21'sd0);
    send_item(REQ_TEST, 21'sd255, 21'sd255);
    send_item(REQ_TEST, 21'sd256, 21'sd0);
    send_item(REQ_SEED, 21'sd100, 21'sd7);
    drain();
    // area of 2048, largest spacing and cell, grid size above range
    set_config(2048, 2048, 65535, 65535, 127, 127);
    send_item(REQ_TEST, 21'sd524287, 21'sd524287);
    send_item(REQ_TEST, 21'sd0, 21'sd524287);
    send_item(REQ_TEST, 21'sd524288, 21'sd0);
    send_item(REQ_SEED, 21'sd262144, 21'sd1);
    drain();
    // tiny cells on a small grid: indices far past the wrap
    set_config(2048, 2048, 300, 1, 3, 5);
    for (int i = 0; i < 6; i++)
      send_item(REQ_TEST, 21'($urandom_range(0, 524287)), 21'($urandom_range(0, 524287)));
    drain();
  endtask

  task automatic test_random(int n_items);
    int per_phase, md, cs;
    per_phase = n_items / 8;
    for (int ph = 0; ph < 8; ph++) begin
      quiet_rx = (ph % 4 == 3);
      no_gaps = (ph % 4 == 3);
      md = $urandom_range(1, 8000);
      cs = (ph % 3 == 0) ? $urandom_range(0, 65535) : (md * 181) / 256;
      case (ph % 4)
        0: set_config(256, 256, 2560, 1810, 64, 64);
        1: set_config($urandom_range(1, 64), $urandom_range(1, 64), md, cs,
                      $urandom_range(0, 127), $urandom_range(0, 127));
        2: set_config(2048, $urandom_range(1, 2048), md * 8, cs,
                      $urandom_range(1, 64), $urandom_range(1, 64));
        default: set_config($urandom_range(1, 2048), $urandom_range(1, 2048),
                            $urandom_range(1, 65535), $urandom_range(1, 65535),
                            $urandom_range(1, 127), $urandom_range(1, 127));
      endcase
      for (int i = 0; i < per_phase; i++) send_random_item();
      drain();
    end
    quiet_rx = 1'b0;
    no_gaps = 1'b0;
  endtask

  task automatic test_backpressure();
    set_config(256, 256, 2560, 1810, 64, 64);
    no_gaps = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 24; i++) send_random_item();
    hold_req = 1'b0;
    no_gaps = 1'b0;
    drain();
  endtask

  // ---------------- receiver ----------------
  initial begin : receiver
    int stall_left;
    bit held;
    stall_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (3000) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!hold_req) begin
        held = 1'b0;
        if (stall_left > 0) begin
          out_stall <= 1'b1;
          stall_left--;
        end else begin
          out_stall <= 1'b0;
          stall_left = quiet_rx ? 0 : pick_gap();
        end
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------- checker ----------------
  always @(posedge clk) begin
    grid_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: status %0d col %0d row %0d", status, cell_col, cell_row);
        failures++;
      end else begin
        e = expected_q.pop_front();
        if (status !== e.st) begin
          $error("status: expected %0d, got %0d", e.st, status);
          failures++;
        end
        if (cell_col !== e.col) begin
          $error("cell_col: expected %0d, got %0d", e.col, cell_col);
          failures++;
        end
        if (cell_row !== e.row) begin
          $error("cell_row: expected %0d, got %0d", e.row, cell_row);
          failures++;
        end
      end
    end
  end

  initial begin : watchdog
    #20000000;
    $display("FAIL poisson_disk_grid_accept");
    $finish;
  end

  initial begin : main
    m_area_w = 12'd256;
    m_area_h = 12'd256;
    m_spacing = 16'd2560;
    m_cell_size = 16'd1810;
    m_cols = 7'd64;
    m_rows = 7'd64;
    clear_grid();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random(1240);
    drain();
    repeat (200) @(posedge clk);
    if (failures == 0 && expected_q.size() == 0) begin
      $display("PASS poisson_disk_grid_accept");
    end else begin
      $display("FAIL poisson_disk_grid_accept");
    end
    $finish;
  end

endmodule
